@@ hdl/lici_pkg.sv @@
// Package for the LiCi 64/128 block encryption pipeline.
// Holds widths, round count, config register codes and the S-box functions.
// No dependencies.
package lici_pkg;

  localparam int BLOCK_W     = 64;
  localparam int HALF_W      = 32;
  localparam int KEY_HALF_W  = 64;
  localparam int ROUND_COUNT = 31;
  localparam int RND_W       = 5;
  localparam int KEY_ROT     = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd1;

  typedef logic [HALF_W-1:0]     half_t;
  typedef logic [KEY_HALF_W-1:0] key_half_t;
  typedef logic [RND_W-1:0]      rnd_t;

  typedef struct packed {
    half_t     left;
    half_t     right;
    key_half_t kh;
    key_half_t kl;
  } lici_state_t;

  function automatic logic [3:0] sub_nib(input logic [3:0] n);
    logic [3:0] r;
    unique case (n)
      4'h0: r = 4'h3;
      4'h1: r = 4'hf;
      4'h2: r = 4'he;
      4'h3: r = 4'h1;
      4'h4: r = 4'h0;
      4'h5: r = 4'ha;
      4'h6: r = 4'h5;
      4'h7: r = 4'h8;
      4'h8: r = 4'hc;
      4'h9: r = 4'h4;
      4'ha: r = 4'hb;
      4'hb: r = 4'h2;
      4'hc: r = 4'h9;
      4'hd: r = 4'h7;
      4'he: r = 4'h6;
      default: r = 4'hd;
    endcase
    return r;
  endfunction

  function automatic half_t sub_word(input half_t w);
    half_t r;
    for (int n = 0; n < HALF_W / 4; n++) begin
      r[n*4 +: 4] = sub_nib(w[n*4 +: 4]);
    end
    return r;
  endfunction

endpackage

@@ hdl/lici_pt_if.sv @@
// Request channel carrying one plaintext block.
// Depends on lici_pkg for the block width.
interface lici_pt_if import lici_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BLOCK_W-1:0] plaintext;

  modport source (output valid, output plaintext, input ready);
  modport sink   (input valid, input plaintext, output ready);
endinterface

@@ hdl/lici_ct_if.sv @@
// Result channel carrying one ciphertext block.
// Depends on lici_pkg for the block width.
interface lici_ct_if import lici_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BLOCK_W-1:0] ciphertext;

  modport source (output valid, output ciphertext, input ready);
  modport sink   (input valid, input ciphertext, output ready);
endinterface

@@ hdl/lici_block_encrypt.sv @@
// Top level of the LiCi 64/128 block encryption pipeline.
// Depends on lici_pkg, lici_pt_if, lici_ct_if and lici_round_cell.
//
// Usage:
//   in_if  : plaintext requests, bits 63:32 are the left half.
//   out_if : ciphertext results, same half order.
//   cfg_*  : write cfg_index 0 for key_high, 1 for key_low, other indexes are
//            ignored; write only while no request is in flight. Each request
//            samples both key registers when it is accepted.
// Path: an accepted block passes through the registered round cells in order,
//   one cell per round, before out_if.valid rises with its result.
// Throughput: one block per cycle unless out_if.ready stalls, through a chain
//   of 31 round cells, each holding the block halves and the running 128-bit key.
// Stall: when out_if.ready is low the last cell holds its result; earlier
//   cells keep filling bubbles, so in_if.ready drops only when every cell
//   holds a block.
// Reset: rst_n (synchronous) empties all cells and clears both keys to zero.
module lici_block_encrypt import lici_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  lici_pt_if.sink              in_if,
  lici_ct_if.source            out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  key_half_t   key_high_r;
  key_half_t   key_low_r;
  logic        vld [ROUND_COUNT+1];
  logic        rdy [ROUND_COUNT+1];
  lici_state_t st  [ROUND_COUNT+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_HIGH: key_high_r <= cfg_wdata;
        CFG_KEY_LOW:  key_low_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign vld[0]         = in_if.valid;
  assign in_if.ready    = rdy[0];
  assign st[0].left     = in_if.plaintext[BLOCK_W-1:HALF_W];
  assign st[0].right    = in_if.plaintext[HALF_W-1:0];
  assign st[0].kh       = key_high_r;
  assign st[0].kl       = key_low_r;

  for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_cell
    lici_round_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .rnd      (RND_W'(i)),
      .up_valid (vld[i]),
      .up_ready (rdy[i]),
      .up_state (st[i]),
      .dn_valid (vld[i+1]),
      .dn_ready (rdy[i+1]),
      .dn_state (st[i+1])
    );
  end

  assign out_if.valid      = vld[ROUND_COUNT];
  assign rdy[ROUND_COUNT]  = out_if.ready;
  assign out_if.ciphertext = {st[ROUND_COUNT].left, st[ROUND_COUNT].right};

endmodule

@@ hdl/lici_round_cell.sv @@
// One LiCi round plus one key schedule step, registered, with valid/ready.
// Depends on lici_pkg for the state struct and the S-box.
module lici_round_cell import lici_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  rnd_t        rnd,
  input  logic        up_valid,
  output logic        up_ready,
  input  lici_state_t up_state,
  output logic        dn_valid,
  input  logic        dn_ready,
  output lici_state_t dn_state
);

  logic        valid_r;
  lici_state_t state_r;
  lici_state_t state_nxt;
  half_t       s;
  half_t       nl;
  half_t       nr;
  key_half_t   kl_rot;
  key_half_t   kh_rot;
  key_half_t   kl_sub;

  always_comb begin
    s      = sub_word(up_state.left);
    nl     = up_state.right ^ s ^ up_state.kl[HALF_W-1:0];
    nl     = {nl[HALF_W-4:0], nl[HALF_W-1 -: 3]};
    nr     = s ^ nl ^ up_state.kl[KEY_HALF_W-1:HALF_W];
    nr     = {nr[6:0], nr[HALF_W-1:7]};
    kl_rot = {up_state.kl[KEY_HALF_W-KEY_ROT-1:0], up_state.kh[KEY_HALF_W-1 -: KEY_ROT]};
    kh_rot = {up_state.kh[KEY_HALF_W-KEY_ROT-1:0], up_state.kl[KEY_HALF_W-1 -: KEY_ROT]};
    kl_sub = {kl_rot[KEY_HALF_W-1:8], sub_nib(kl_rot[7:4]), sub_nib(kl_rot[3:0])};
    kl_sub[KEY_HALF_W-1 -: RND_W] = kl_sub[KEY_HALF_W-1 -: RND_W] ^ rnd;
    state_nxt.left  = nl;
    state_nxt.right = nr;
    state_nxt.kh    = kh_rot;
    state_nxt.kl    = kl_sub;
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_state = state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hdl/lici_checker.sv @@
// Port-level checks for lici_block_encrypt, bound to the top level.
// Depends on lici_pkg for the block width.
module lici_checker import lici_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [BLOCK_W-1:0] ciphertext
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while output side can drain");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(ciphertext))
    else $error("stalled result changed");

  a_drop_only_taken: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(out_valid) |-> $past(out_ready))
    else $error("result dropped without being taken");

endmodule

bind lici_block_encrypt lici_checker u_lici_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .ciphertext (out_if.ciphertext)
);

@@ bench/lici_block_encrypt_test.sv @@
// Self-checking bench for lici_block_encrypt: directed and random plaintext
// blocks under several keys, predicted ciphertext checked in order.
// Depends on lici_pkg, lici_pt_if, lici_ct_if and the block's RTL.
module lici_block_encrypt_test;
  import lici_pkg::*;

  // S-box, nibble i of the constant is the substitute of i
  localparam logic [63:0] SBOX_NIBS = 64'hd6792b4c_85a01ef3;
  localparam logic [63:0] ALL_ONES  = 64'hffff_ffff_ffff_ffff;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lici_pt_if pt_if ();
  lici_ct_if ct_if ();

  lici_block_encrypt dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (pt_if),
    .out_if    (ct_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  key_half_t key_high_q;
  key_half_t key_low_q;
  logic [BLOCK_W-1:0] ct_expected [$];
  int error_count;
  bit no_idle;
  int hold_left;
  int stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [3:0] subst_nibble(input logic [3:0] n);
    return SBOX_NIBS[n*4 +: 4];
  endfunction

  function automatic half_t subst_half(input half_t w);
    half_t r;
    for (int n = 0; n < 8; n++) begin
      r[n*4 +: 4] = subst_nibble(w[n*4 +: 4]);
    end
    return r;
  endfunction

  function automatic logic [BLOCK_W-1:0] lici_encrypt(input logic [BLOCK_W-1:0] pt,
                                                      input key_half_t kh_in,
                                                      input key_half_t kl_in);
    half_t l, r, s, x, y;
    key_half_t kh, kl, t;
    l = pt[63:32];
    r = pt[31:0];
    kh = kh_in;
    kl = kl_in;
    for (int rnd = 0; rnd < ROUND_COUNT; rnd++) begin
      s = subst_half(l);
      x = r ^ s ^ kl[31:0];
      l = {x[28:0], x[31:29]};
      y = s ^ l ^ kl[63:32];
      r = {y[6:0], y[31:7]};
      t = kl;
      kl = {kl[50:0], kh[63:51]};
      kh = {kh[50:0], t[63:51]};
      kl[7:0] = {subst_nibble(kl[7:4]), subst_nibble(kl[3:0])};
      kl[63:59] = kl[63:59] ^ rnd[4:0];
    end
    return {l, r};
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [63:0] rand_word64();
    logic [63:0] v;
    case ($urandom_range(0, 11))
      0: v = 64'h0;
      1: v = ALL_ONES;
      2: v = {32'h0, 32'($urandom)};
      3: v = {32'($urandom), 32'hffff_ffff};
      4: v = 64'h1 << $urandom_range(0, 63);
      default: v = {32'($urandom), 32'($urandom)};
    endcase
    return v;
  endfunction

  // result side: random stalls, or a long hold-off when requested
  initial begin
    ct_if.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        ct_if.ready = 1'b0;
        hold_left--;
      end else if (no_idle) begin
        ct_if.ready = 1'b1;
      end else if (stall_left > 0) begin
        ct_if.ready = 1'b0;
        stall_left--;
      end else begin
        ct_if.ready = 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && ct_if.valid && ct_if.ready) begin
      if (ct_expected.size() == 0) begin
        $error("ciphertext: no request pending, actual %h", ct_if.ciphertext);
        error_count++;
      end else begin
        logic [BLOCK_W-1:0] want;
        want = ct_expected.pop_front();
        if (ct_if.ciphertext !== want) begin
          $error("ciphertext mismatch: expected %h, actual %h", want, ct_if.ciphertext);
          error_count++;
        end
      end
    end
  end

  task automatic send_block(input logic [BLOCK_W-1:0] pt);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      pt_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pt_if.valid = 1'b1;
    pt_if.plaintext = pt;
    do @(posedge clk); while (!pt_if.ready);
    ct_expected.push_back(lici_encrypt(pt, key_high_q, key_low_q));
  endtask

  // stop offering requests and wait for every pending ciphertext
  task automatic finish_phase();
    @(negedge clk);
    pt_if.valid = 1'b0;
    while (ct_expected.size() != 0) @(posedge clk);
  endtask

  task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input key_half_t value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    if (idx == CFG_KEY_HIGH) key_high_q = value;
    else key_low_q = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_key(input key_half_t hi, input key_half_t lo);
    finish_phase();
    write_key(CFG_KEY_HIGH, hi);
    write_key(CFG_KEY_LOW, lo);
  endtask

  task automatic send_edge_blocks();
    send_block(64'h0);
    send_block(ALL_ONES);
    send_block(64'h5555_5555_5555_5555);
    send_block(64'haaaa_aaaa_aaaa_aaaa);
    send_block(64'h0000_0000_ffff_ffff);
    send_block(64'hffff_ffff_0000_0000);
  endtask

  task automatic test_reset_key();
    send_edge_blocks();
  endtask

  task automatic test_key_extremes();
    set_key(ALL_ONES, ALL_ONES);
    send_edge_blocks();
    set_key(ALL_ONES, 64'h0);
    send_block(64'h0);
    send_block(ALL_ONES);
    set_key(64'h0, ALL_ONES);
    send_block(64'h0123_4567_89ab_cdef);
    send_block(64'hfedc_ba98_7654_3210);
  endtask

  task automatic test_random_stream();
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: set_key(ALL_ONES, 64'h0);
        1: set_key(64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001);
        default: set_key(rand_word64(), rand_word64());
      endcase
      no_idle = (phase == 3);
      for (int n = 0; n < 130; n++) begin
        send_block(rand_word64());
      end
    end
    no_idle = 1'b0;
  endtask

  // receiver holds off long enough for the pipeline to fill and stall input
  task automatic test_backpressure();
    set_key(rand_word64(), rand_word64());
    no_idle = 1'b1;
    @(posedge clk);
    hold_left = 120;
    for (int n = 0; n < 60; n++) begin
      send_block(rand_word64());
    end
    no_idle = 1'b0;
  endtask

  task automatic test_sender_pause();
    set_key(rand_word64(), rand_word64());
    for (int n = 0; n < 20; n++) send_block(rand_word64());
    finish_phase();
    for (int n = 0; n < 20; n++) send_block(rand_word64());
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_KEY_HIGH;
    cfg_wdata = '0;
    pt_if.valid = 1'b0;
    pt_if.plaintext = '0;
    key_high_q = '0;
    key_low_q = '0;
    error_count = 0;
    no_idle = 1'b0;
    hold_left = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_reset_key();
    test_key_extremes();
    test_random_stream();
    test_backpressure();
    test_sender_pause();

    finish_phase();
    repeat (40) @(posedge clk);
    if (ct_expected.size() != 0) begin
      $error("ciphertext: %0d results never arrived", ct_expected.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/lici_pkg.sv
hdl/lici_pt_if.sv
hdl/lici_ct_if.sv
hdl/lici_round_cell.sv
hdl/lici_block_encrypt.sv
hdl/lici_checker.sv
bench/lici_block_encrypt_test.sv
